// ===== sv/lpg_pkg.sv =====
// shared types, constants and the gamma 2.6 lookup table for the led pixel serializer
// no dependencies; imported by every module of the block

package lpg_pkg;

  localparam int COLOR_BITS = 8;
  localparam int NUM_CHANNELS = 3;
  localparam int SYMBOLS_PER_PIXEL = NUM_CHANNELS * COLOR_BITS;
  localparam int TICK_BITS = 15;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 15;
  localparam int SYM_COUNT_BITS = $clog2(SYMBOLS_PER_PIXEL);
  localparam int PROD_BITS = 3 * COLOR_BITS;
  localparam int REM_BITS = 18;
  // full scale squared, the divisor of the brightness scaling
  localparam int SCALE_DIV = 65025;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_CEILING    = 3'd1,
    REG_GREEN_FIRST = 3'd2,
    REG_ZERO_HIGH  = 3'd3,
    REG_ZERO_LOW   = 3'd4,
    REG_ONE_HIGH   = 3'd5,
    REG_ONE_LOW    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] brightness;
    logic [COLOR_BITS-1:0] ceiling;
    logic                  green_first;
    logic [TICK_BITS-1:0]  zero_high;
    logic [TICK_BITS-1:0]  zero_low;
    logic [TICK_BITS-1:0]  one_high;
    logic [TICK_BITS-1:0]  one_low;
  } lpg_cfg_t;

  typedef logic [NUM_CHANNELS-1:0][COLOR_BITS-1:0] lpg_chan_t;
  typedef logic [255:0][COLOR_BITS-1:0] gamma_rom_t;

  // exact rounding of 255 * (i/255)^2.6: candidate v is reached when
  // (2v-1)^5 * 255^8 <= 32 * i^13, evaluated in wide integers
  function automatic gamma_rom_t lpg_build_gamma();
    gamma_rom_t    lut;
    logic [127:0]  lhs;
    logic [127:0]  rhs;
    int            v;
    logic          done;
    v = 0;
    for (int i = 0; i < 256; i++) begin
      done = 1'b0;
      rhs = 128'd32;
      for (int k = 0; k < 13; k++) rhs = rhs * 128'(i);
      for (int j = 0; j < 256; j++) begin
        if (!done && v < 255) begin
          lhs = 128'd1;
          for (int k = 0; k < 5; k++) lhs = lhs * 128'(2 * v + 1);
          for (int k = 0; k < 8; k++) lhs = lhs * 128'd255;
          if (lhs <= rhs) v = v + 1;
          else done = 1'b1;
        end
      end
      lut[i] = COLOR_BITS'(v);
    end
    return lut;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = lpg_build_gamma();

endpackage

// ===== sv/lpg_scale.sv =====
// four stage brightness scaling: ch * brightness * ceiling / 65025 per channel
// depends on lpg_pkg

module lpg_scale (
  input  logic              clk,
  input  logic              rst,
  input  lpg_pkg::lpg_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpg_pkg::lpg_chan_t in_chan,
  output logic              out_valid,
  input  logic              out_ready,
  output lpg_pkg::lpg_chan_t out_chan
);
  import lpg_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [NUM_CHANNELS-1:0][2*COLOR_BITS-1:0] prod1;
  logic [NUM_CHANNELS-1:0][PROD_BITS-1:0]    prod2;
  logic [NUM_CHANNELS-1:0][COLOR_BITS-1:0]   quot3;
  logic [NUM_CHANNELS-1:0][REM_BITS-1:0]     rem3;
  logic [NUM_CHANNELS-1:0][COLOR_BITS-1:0]   quot4;

  // a stage moves when it is empty or the next one moves
  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: channel times brightness
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        prod1[c] <= (2*COLOR_BITS)'(in_chan[c]) * (2*COLOR_BITS)'(cfg.brightness);
      end
    end
  end

  // stage 2: times ceiling
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        prod2[c] <= PROD_BITS'(prod1[c]) * PROD_BITS'(cfg.ceiling);
      end
    end
  end

  // stage 3: quotient estimate from the top byte and its remainder
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        quot3[c] <= prod2[c][PROD_BITS-1:PROD_BITS-COLOR_BITS];
        rem3[c]  <= REM_BITS'(prod2[c] -
                    PROD_BITS'(prod2[c][PROD_BITS-1:PROD_BITS-COLOR_BITS]) *
                    PROD_BITS'(SCALE_DIV));
      end
    end
  end

  // stage 4: the estimate is low by at most two
  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (rem3[c] >= REM_BITS'(2 * SCALE_DIV)) quot4[c] <= quot3[c] + COLOR_BITS'(2);
        else if (rem3[c] >= REM_BITS'(SCALE_DIV)) quot4[c] <= quot3[c] + COLOR_BITS'(1);
        else quot4[c] <= quot3[c];
      end
    end
  end

  assign out_valid = v4;
  assign out_chan  = quot4;

endmodule

// ===== sv/lpg_gamma.sv =====
// gamma table lookup and channel ordering stage, gives the 24 bit send word
// depends on lpg_pkg

module lpg_gamma (
  input  logic               clk,
  input  logic               rst,
  input  lpg_pkg::lpg_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpg_pkg::lpg_chan_t in_chan,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [lpg_pkg::SYMBOLS_PER_PIXEL-1:0] out_word
);
  import lpg_pkg::*;

  logic                  valid;
  logic [COLOR_BITS-1:0] red_g, green_g, blue_g;

  assign in_ready = !valid || out_ready;

  // constant table reads, one per channel
  assign red_g   = GAMMA_ROM[in_chan[0]];
  assign green_g = GAMMA_ROM[in_chan[1]];
  assign blue_g  = GAMMA_ROM[in_chan[2]];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // first channel sent sits in the top byte
  always_ff @(posedge clk) begin
    if (in_ready) begin
      if (cfg.green_first) out_word <= {green_g, red_g, blue_g};
      else out_word <= {red_g, green_g, blue_g};
    end
  end

  assign out_valid = valid;

endmodule

// ===== sv/lpg_serial.sv =====
// symbol serializer: shifts a 24 bit word out msb first, one symbol a cycle
// while the output is not held, into an output register; depends on lpg_pkg

module lpg_serial (
  input  logic              clk,
  input  logic              rst,
  input  lpg_pkg::lpg_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [lpg_pkg::SYMBOLS_PER_PIXEL-1:0] in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_bit,
  output logic [lpg_pkg::TICK_BITS-1:0] out_high,
  output logic [lpg_pkg::TICK_BITS-1:0] out_low,
  output logic              out_last
);
  import lpg_pkg::*;

  logic [SYMBOLS_PER_PIXEL-1:0] shift;
  logic [SYM_COUNT_BITS-1:0]    cnt;
  logic                         busy;
  logic                         out_free;
  logic                         emit;
  logic                         final_sym;
  logic                         load;

  assign out_free  = !out_valid || out_ready;
  assign emit      = busy && out_free;
  assign final_sym = (cnt == SYM_COUNT_BITS'(SYMBOLS_PER_PIXEL - 1));
  assign in_ready  = !busy || (emit && final_sym);
  assign load      = in_valid && in_ready;

  // control: word ownership, symbol count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a fresh word takes over the count, also on the last symbol's cycle
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        cnt <= cnt + SYM_COUNT_BITS'(1);
        if (final_sym) busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: shift register and symbol timing
  always_ff @(posedge clk) begin
    if (emit) begin
      out_bit  <= shift[SYMBOLS_PER_PIXEL-1];
      out_high <= shift[SYMBOLS_PER_PIXEL-1] ? cfg.one_high : cfg.zero_high;
      out_low  <= shift[SYMBOLS_PER_PIXEL-1] ? cfg.one_low : cfg.zero_low;
      out_last <= final_sym;
    end
    if (load) begin
      shift <= in_word;
    end else if (emit) begin
      shift <= {shift[SYMBOLS_PER_PIXEL-2:0], 1'b0};
    end
  end

  // mid pixel, a symbol is always waiting in the output register
  a_mid_pixel_valid: assert property (@(posedge clk) disable iff (rst)
    busy && cnt != '0 |-> out_valid)
    else $error("serializer lost a symbol mid pixel");

  // a waiting last symbol means the word is done or a fresh one is loaded
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> !busy || cnt == '0)
    else $error("last symbol shown while word still shifting");

  // output drains when no word is left
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !busy |=> !out_valid)
    else $error("symbol repeated after drain");

endmodule

// ===== sv/led_pixel_gamma_serializer.sv =====
// top level of the led pixel gamma serializer: configuration registers and
// the scale, gamma and serializer stages; depends on lpg_pkg and its submodules

// Takes one RGB pixel per transfer and sends 24 pulse symbols, one per cycle
// while m_tready does not hold the output, most significant bit first,
// green-red-blue or red-green-blue by green_first. The next pixel is taken
// while the last symbol of the current one is still waiting, so a continuous
// stream keeps the output busy. From input transfer to first symbol a pixel
// passes four scaling stages, one gamma stage, the serializer load and the
// output register. The user must write configuration over the cfg port only
// while no pixel is in flight; the block itself does not enforce this.
// cfg_ready is always high and writes to unused indexes are dropped.

module led_pixel_gamma_serializer (
  input  logic        clk,
  input  logic        rst,
  // pixel input: red [7:0], green [15:8], blue [23:16]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  // symbol output: bit_value [0], high_ticks [15:1], low_ticks [30:16], zero [31]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lpg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import lpg_pkg::*;

  lpg_cfg_t  cfg;
  lpg_chan_t in_chan;
  lpg_chan_t scaled;
  logic      sc_valid, sc_ready;
  logic      gm_valid, gm_ready;
  logic [SYMBOLS_PER_PIXEL-1:0] word;
  logic      sym_bit;
  logic [TICK_BITS-1:0] sym_high, sym_low;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness  <= COLOR_BITS'(255);
      cfg.ceiling     <= COLOR_BITS'(255);
      cfg.green_first <= 1'b1;
      cfg.zero_high   <= TICK_BITS'(3);
      cfg.zero_low    <= TICK_BITS'(9);
      cfg.one_high    <= TICK_BITS'(9);
      cfg.one_low     <= TICK_BITS'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BRIGHTNESS:  cfg.brightness  <= cfg_data[COLOR_BITS-1:0];
        REG_CEILING:     cfg.ceiling     <= cfg_data[COLOR_BITS-1:0];
        REG_GREEN_FIRST: cfg.green_first <= cfg_data[0];
        REG_ZERO_HIGH:   cfg.zero_high   <= cfg_data[TICK_BITS-1:0];
        REG_ZERO_LOW:    cfg.zero_low    <= cfg_data[TICK_BITS-1:0];
        REG_ONE_HIGH:    cfg.one_high    <= cfg_data[TICK_BITS-1:0];
        REG_ONE_LOW:     cfg.one_low     <= cfg_data[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // channel lanes: red, green, blue
  assign in_chan[0] = s_tdata[7:0];
  assign in_chan[1] = s_tdata[15:8];
  assign in_chan[2] = s_tdata[23:16];

  lpg_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_chan   (in_chan),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_chan  (scaled)
  );

  lpg_gamma u_gamma (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_chan   (scaled),
    .out_valid (gm_valid),
    .out_ready (gm_ready),
    .out_word  (word)
  );

  lpg_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (gm_valid),
    .in_ready  (gm_ready),
    .in_word   (word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bit   (sym_bit),
    .out_high  (sym_high),
    .out_low   (sym_low),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, sym_low, sym_high, sym_bit};

endmodule
